// File: sv/egcd_pkg.sv
// Shared types and constants for the extended gcd / modular inverse block.
`default_nettype none
package egcd_pkg;

    typedef enum logic [1:0] {
        ACT_GCD = 2'd0,
        ACT_INV = 2'd1,
        ACT_CONG = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_STEP,
        ST_POST,
        ST_MODX,
        ST_CDIV,
        ST_KMOD,
        ST_MULMOD,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// File: sv/extended_gcd_modular_inverse.sv
// Top level: extended Euclid sequencer around a shared serial divider.
//
// Usage: an item request enters on s_axis (tdata = action, first_operand,
// second_operand, rhs from bit 0 up); one result leaves on m_axis (tdata =
// coef_x, coef_y, divisor, answer; tuser = solvable). s_axis_tready is high
// only while the sequencer is idle; one item is worked at a time.
// Each Euclid round takes a division, a shift-add pass over the
// quotient bits for the two coefficient products, and two more states
// (step and check). After the last round come the post-processing steps
// (congruence: two divisions, two reductions and the modular multiply).
// Worst case with 63-bit operands is about 92 rounds.
// The result waits in an output register until m_axis_tready; the next
// request is taken and worked meanwhile, and the sequencer holds in its last
// state until the earlier result has been taken.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
// m_axis_tvalid; no clearing pass is needed.
`default_nettype none
module extended_gcd_modular_inverse
    import egcd_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // action[1:0], first_operand[64:2], second_operand[127:65], rhs[190:128]
    input  wire logic [191:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // coef_x[63:0], coef_y[127:64], divisor[190:128], answer[253:191]
    output logic [255:0]      m_axis_tdata,
    // solvable
    output logic              m_axis_tuser
);
    localparam int W = WIDTH;

    state_t state_reg, state_next;
    logic [1:0] act_reg;
    logic [W-1:0] pr_reg, cr_reg, px_reg, cx_reg, py_reg, cy_reg;
    logic [W-1:0] b_reg, c_reg, q_reg, qx_reg, qy_reg, mx_reg, my_reg;
    logic [W-1:0] m2_reg, x0_reg, k_reg, acc_reg, ans_reg;
    logic [$clog2(W+1)-1:0] bit_reg;
    logic ok_reg;
    logic outv_reg;
    logic [63:0] ox_reg, oy_reg;
    logic [62:0] od_reg, oa_reg;
    logic ou_reg;
    logic phase_reg;
    logic [1:0] sub_reg;
    logic out_load;

    logic div_start;
    logic [W-1:0] div_a, div_b;
    logic div_done;
    logic [W-1:0] div_q, div_r;

    logic [W-1:0] in_a, in_b, in_c;
    logic neg_x;
    logic [W-1:0] mag_x;
    logic [W:0] acc2, acc3;
    logic [W-1:0] acc_sh, acc_add;

    assign in_a = W'(s_axis_tdata[64:2]) & {1'b0, {(W-1){1'b1}}};
    assign in_b = W'(s_axis_tdata[127:65]) & {1'b0, {(W-1){1'b1}}};
    assign in_c = W'(s_axis_tdata[190:128]) & {1'b0, {(W-1){1'b1}}};

    assign neg_x = px_reg[W-1];
    assign mag_x = neg_x ? (W'(0) - px_reg) : px_reg;

    // result moves to the output register once the old one is gone
    assign out_load = (state_reg == ST_DONE) && (!outv_reg || m_axis_tready);

    egcd_divider #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(div_a), .dvsr(div_b),
        .done(div_done), .quot(div_q), .rem(div_r)
    );

    // mul_mod step: acc = 2*acc mod m, then optionally + x0 mod m
    always_comb
    begin
        acc2 = {acc_reg, 1'b0};
        acc_sh = (acc2 >= {1'b0, m2_reg}) ? W'(acc2 - {1'b0, m2_reg}) : acc2[W-1:0];
        acc3 = {1'b0, acc_sh} + {1'b0, x0_reg};
        acc_add = (acc3 >= {1'b0, m2_reg}) ? W'(acc3 - {1'b0, m2_reg}) : acc3[W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_axis_tvalid) state_next = ST_CHECK;
            ST_CHECK:  state_next = (cr_reg != '0) ? ST_DIV : ST_POST;
            ST_DIV:    if (div_done) state_next = ST_MUL;
            ST_MUL:    if (q_reg == '0) state_next = ST_STEP;
            ST_STEP:   state_next = ST_CHECK;
            ST_POST:
            begin
                if (act_reg == ACT_CONG && b_reg != '0 && pr_reg != '0)
                    state_next = ST_CDIV;
                else if (act_reg == ACT_INV && b_reg != '0 && pr_reg == W'(1))
                    state_next = ST_MODX;
                else
                    state_next = ST_DONE;
            end
            ST_CDIV:
            begin
                // first pass c / gcd, second pass b / gcd
                if (div_done)
                begin
                    if (sub_reg != 2'd0)
                        state_next = ST_KMOD;
                    else if (div_r != '0)
                        state_next = ST_DONE;
                end
            end
            ST_KMOD:   if (div_done) state_next = ST_MODX;
            ST_MODX:   if (div_done)
                           state_next = (act_reg == ACT_CONG) ? ST_MULMOD : ST_DONE;
            ST_MULMOD: if (bit_reg == '0) state_next = ST_DONE;
            ST_DONE:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // divider start and operands: sub-phases are sequenced by a phase flag
    always_comb
    begin
        div_start = 1'b0;
        div_a = pr_reg;
        div_b = cr_reg;
        unique case (state_reg)
            ST_DIV:
            begin
                div_start = !phase_reg;
            end
            ST_CDIV:
            begin
                div_start = !phase_reg;
                div_a = (sub_reg == 2'd0) ? c_reg : b_reg;
                div_b = pr_reg;
            end
            ST_KMOD:
            begin
                div_start = !phase_reg;
                div_a = k_reg;
                div_b = m2_reg;
            end
            ST_MODX:
            begin
                div_start = !phase_reg;
                div_a = mag_x;
                div_b = m2_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            outv_reg <= 1'b0;
            phase_reg <= 1'b0;
            sub_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                outv_reg <= 1'b1;
            else if (m_axis_tready)
                outv_reg <= 1'b0;
            if (div_start)
                phase_reg <= 1'b1;
            else if (div_done)
                phase_reg <= 1'b0;
            if (state_reg == ST_POST)
                sub_reg <= 2'd0;
            else if (state_reg == ST_CDIV && div_done)
                sub_reg <= sub_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                act_reg <= s_axis_tdata[1:0];
                pr_reg <= in_a;
                cr_reg <= in_b;
                b_reg <= in_b;
                c_reg <= in_c;
                px_reg <= W'(1);
                cx_reg <= '0;
                py_reg <= '0;
                cy_reg <= W'(1);
                ok_reg <= 1'b0;
                ans_reg <= '0;
            end
            ST_DIV:
                if (div_done)
                begin
                    q_reg <= div_q;
                    qx_reg <= '0;
                    qy_reg <= '0;
                    mx_reg <= cx_reg;
                    my_reg <= cy_reg;
                end
            ST_MUL:
                // shift-add over the quotient bits, LSB first
                if (q_reg != '0)
                begin
                    if (q_reg[0])
                    begin
                        qx_reg <= qx_reg + mx_reg;
                        qy_reg <= qy_reg + my_reg;
                    end
                    mx_reg <= {mx_reg[W-2:0], 1'b0};
                    my_reg <= {my_reg[W-2:0], 1'b0};
                    q_reg <= {1'b0, q_reg[W-1:1]};
                end
            ST_STEP:
            begin
                // divider still holds the remainder of this round
                pr_reg <= cr_reg;
                cr_reg <= div_r;
                px_reg <= cx_reg;
                cx_reg <= px_reg - qx_reg;
                py_reg <= cy_reg;
                cy_reg <= py_reg - qy_reg;
            end
            ST_POST:
            begin
                ok_reg <= (act_reg == ACT_GCD);
                m2_reg <= b_reg;
            end
            ST_CDIV:
                if (div_done)
                begin
                    if (sub_reg == 2'd0)
                        k_reg <= div_q;
                    else
                        m2_reg <= div_q;
                end
            ST_KMOD:
                if (div_done) k_reg <= div_r;
            ST_MODX:
                if (div_done)
                begin
                    x0_reg <= (neg_x && div_r != '0) ? m2_reg - div_r : div_r;
                    if (act_reg == ACT_INV)
                    begin
                        ans_reg <= (neg_x && div_r != '0) ? m2_reg - div_r : div_r;
                        ok_reg <= 1'b1;
                    end
                    acc_reg <= '0;
                    bit_reg <= ($clog2(W+1))'(W);
                end
            ST_MULMOD:
                if (bit_reg != '0)
                begin
                    acc_reg <= k_reg[W-1] ? acc_add : acc_sh;
                    k_reg <= {k_reg[W-2:0], 1'b0};
                    bit_reg <= bit_reg - 1'b1;
                end
                else
                begin
                    ans_reg <= acc_reg;
                    ok_reg <= 1'b1;
                end
            ST_DONE:
                if (out_load)
                begin
                    ox_reg <= 64'(signed'(px_reg));
                    oy_reg <= 64'(signed'(py_reg));
                    od_reg <= 63'(pr_reg);
                    oa_reg <= 63'(ans_reg);
                    ou_reg <= ok_reg;
                end
            default:
            begin
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = outv_reg;
    assign m_axis_tdata = {2'b00, oa_reg, od_reg, oy_reg, ox_reg};
    assign m_axis_tuser = ou_reg;
endmodule
`default_nettype wire

// File: sv/egcd_divider.sv
// Shared restoring divider: one quotient bit per cycle.
`default_nettype none
module egcd_divider
    import egcd_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] dvsr,
    output logic              done,
    output logic [W-1:0]      quot,
    output logic [W-1:0]      rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] q_reg, q_next;
    logic [W-1:0] r_reg, r_next;
    logic [W-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [W:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[W-1]};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = dvsr;
            cnt_next = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = W'(trial - {1'b0, d_reg});
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem = r_reg;
endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Testbench for extended_gcd_modular_inverse: random and directed requests, self-checking.
`timescale 1ns / 1ps
module tb_top;
    import egcd_pkg::*;

    typedef struct {
        action_t     act;
        logic [62:0] a;
        logic [62:0] b;
        logic [62:0] c;
    } request_t;

    typedef struct {
        logic [63:0] cx;
        logic [63:0] cy;
        logic [62:0] g;
        logic [62:0] ans;
        logic        ok;
    } solution_t;

    localparam logic [62:0] MAXV = {63{1'b1}};
    localparam int WATCHDOG_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [255:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         s_axis_tready_seen;

    request_t  pending_reqs[$];
    solution_t expected_solutions[$];
    int        error_count;
    int        idle_cycles;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        recv_hold;

    extended_gcd_modular_inverse #(.WIDTH(64)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // value held as two's complement, reduced into 0..m-1
    function automatic logic [63:0] reduce_signed(logic [63:0] v, logic [63:0] m);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? -v : v;
        r = mag % m;
        if (v[63] && r != 0)
            r = m - r;
        return r;
    endfunction

    function automatic solution_t solve_request(request_t rq);
        solution_t   s;
        logic [63:0] pr, cr, px, cx, py, cy, q, t, m2, x0, k;
        logic [127:0] prod;
        pr = {1'b0, rq.a};
        cr = {1'b0, rq.b};
        px = 1; cx = 0; py = 0; cy = 1;
        while (cr != 0) begin
            q = pr / cr;
            t = pr - q * cr; pr = cr; cr = t;
            t = px - q * cx; px = cx; cx = t;
            t = py - q * cy; py = cy; cy = t;
        end
        s.cx = px;
        s.cy = py;
        s.g = pr[62:0];
        s.ans = 0;
        s.ok = 0;
        case (rq.act)
            ACT_GCD: s.ok = 1;
            ACT_INV:
                if (rq.b != 0 && pr == 1) begin
                    t = reduce_signed(px, {1'b0, rq.b});
                    s.ans = t[62:0];
                    s.ok = 1;
                end
            ACT_CONG:
                if (rq.b != 0 && pr != 0 && ({1'b0, rq.c} % pr) == 0) begin
                    m2 = {1'b0, rq.b} / pr;
                    x0 = reduce_signed(px, m2);
                    k = ({1'b0, rq.c} / pr) % m2;
                    prod = ({64'd0, x0} * {64'd0, k}) % {64'd0, m2};
                    s.ans = prod[62:0];
                    s.ok = 1;
                end
            default: ;
        endcase
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic logic [62:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    function automatic logic [62:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 63'($urandom_range(0, 3));
            1: return 63'($urandom_range(0, 1000));
            2: return 63'($urandom);
            3: return rand63() >> $urandom_range(0, 62);
            default: return rand63();
        endcase
    endfunction

    task automatic add_request(action_t act, logic [62:0] a, logic [62:0] b, logic [62:0] c);
        request_t rq;
        rq.act = act; rq.a = a; rq.b = b; rq.c = c;
        pending_reqs.push_back(rq);
    endtask

    // the driver needs to know whether its current request was taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tready_seen <= 1'b0;
        else
            s_axis_tready_seen <= s_axis_tvalid && s_axis_tready;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else if (!s_axis_tvalid || s_axis_tready_seen) begin
            if (pending_reqs.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
                request_t rq;
                rq = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {1'b0, rq.c, rq.b, rq.a, rq.act};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !recv_hold && ($urandom_range(1, 100) > recv_stall_pct);
    end

    // long hold-off: sender keeps offering while the result sits unread
    initial
    begin
        int n;
        recv_hold = 1'b0;
        wait (rst_n);
        wait (expected_solutions.size() > 0);
        recv_hold = 1'b1;
        for (n = 0; n < 30000; n++)
            @(posedge clk);
        recv_hold = 1'b0;
    end

    // monitor: predict on accepted requests, check on accepted results
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                request_t rq;
                rq.act = action_t'(s_axis_tdata[1:0]);
                rq.a = s_axis_tdata[64:2];
                rq.b = s_axis_tdata[127:65];
                rq.c = s_axis_tdata[190:128];
                expected_solutions.push_back(solve_request(rq));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_solutions.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
                end else begin
                    solution_t e;
                    e = expected_solutions.pop_front();
                    if (m_axis_tdata[63:0] !== e.cx)
                        report_mismatch("coef_x", m_axis_tdata[63:0], e.cx);
                    if (m_axis_tdata[127:64] !== e.cy)
                        report_mismatch("coef_y", m_axis_tdata[127:64], e.cy);
                    if (m_axis_tdata[190:128] !== e.g)
                        report_mismatch("divisor", 64'(m_axis_tdata[190:128]), 64'(e.g));
                    if (m_axis_tdata[253:191] !== e.ans)
                        report_mismatch("answer", 64'(m_axis_tdata[253:191]), 64'(e.ans));
                    if (m_axis_tuser !== e.ok)
                        report_mismatch("solvable", 64'(m_axis_tuser), 64'(e.ok));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** extended_gcd_modular_inverse: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int ph, i;
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners
        add_request(ACT_GCD, 0, 0, 0);
        add_request(ACT_GCD, MAXV, MAXV, MAXV);
        add_request(ACT_GCD, MAXV, MAXV - 1, 0);
        add_request(ACT_GCD, 0, 12, 0);
        add_request(ACT_GCD, 240, 46, 0);
        add_request(ACT_INV, 3, 11, 0);
        add_request(ACT_INV, 5, 0, 0);
        add_request(ACT_INV, 7, 1, 0);
        add_request(ACT_INV, 6, 9, 0);
        add_request(ACT_INV, MAXV - 1, MAXV, 0);
        add_request(ACT_INV, 0, 1, 0);
        add_request(ACT_CONG, 14, 30, 8);
        add_request(ACT_CONG, 14, 30, 7);
        add_request(ACT_CONG, 4, 0, 8);
        add_request(ACT_CONG, 9, 1, 5);
        add_request(ACT_CONG, MAXV - 1, MAXV - 3, MAXV - 1);
        add_request(ACT_CONG, 0, 6, 0);
        add_request(ACT_CONG, 0, 0, 0);
        add_request(ACT_NONE, 240, 46, MAXV);
        add_request(ACT_NONE, 0, 0, 0);
        add_request(ACT_CONG, 1000000007, MAXV, MAXV);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (i = 0; i < 20; i++) begin
                logic [62:0] a, b, c, g;
                a = rand_operand();
                b = rand_operand();
                c = rand_operand();
                // make congruences solvable most of the time
                if ($urandom_range(0, 3) != 0) begin
                    g = 63'($urandom_range(1, 50));
                    c = (c / g) * g;
                    a = (a / g) * g;
                    b = (b / g) * g;
                end
                add_request(action_t'($urandom_range(0, 3)), a, b, c);
            end
            wait (pending_reqs.size() == 0);
        end
        @(posedge clk);
        wait (!s_axis_tvalid && expected_solutions.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("** extended_gcd_modular_inverse: PASSED **");
        else
            $display("** extended_gcd_modular_inverse: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
sv/egcd_pkg.sv
sv/egcd_divider.sv
sv/extended_gcd_modular_inverse.sv
sim/tb_top.sv
